[src/spq_pkg.sv]
// shared constants and types of the stable minimum priority queue
`default_nettype none
package spq_pkg;
	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int ELEM_W   = 32;
	localparam int PRI_W    = 16;
	localparam int IN_W     = ELEM_W + PRI_W;
	localparam int OUT_W    = 56;

	typedef logic [CNT_W-1:0] count_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef logic signed [PRI_W-1:0] pri_t;

	typedef struct packed {
		pri_t  pri;
		elem_t elem;
	} entry_t;

	typedef enum logic {
		MODE_INSERT = 1'b0,
		MODE_REMOVE = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;
endpackage
`default_nettype wire

[src/stable_min_priority_queue.sv]
// top level of the stable minimum priority queue: entry memory, scan sequencer, result register
// timing: an insert, or a remove on an empty queue, shows its result in the cycle after acceptance
// timing: a remove on n entries reads all n old slots, then registers the result
// flow: one item at a time, none is taken during a removal scan or while a result waits;
// the scan is paced by the single read port of the entry memory, stepped once per cycle
// reset: arst_n clears the fill count, minimum position and handshake state; entry memory
// is not cleared, only entries below the fill count are ever read
`default_nettype none
module stable_min_priority_queue (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	input  wire logic [spq_pkg::IN_W-1:0] s_tdata,  // element[31:0], priority_req[47:32]
	input  wire logic                     s_tuser,  // mode
	output logic                          m_tvalid,
	input  wire logic                     m_tready,
	output logic [spq_pkg::OUT_W-1:0]     m_tdata   // status[1:0], is_empty[2],
	                                                // min_element[34:3], min_priority[50:35],
	                                                // fill_level[55:51]
);
	import spq_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_SCAN
	} state_t;

	// entry memory, one word per slot in arrival order
	entry_t mem [CAPACITY];
	entry_t rd_data;
	idx_t   rd_addr;
	logic   wr_en;
	idx_t   wr_addr;
	entry_t wr_data;

	state_t state_q;
	count_t count_q;
	idx_t   min_pos_q;
	entry_t min_q;          // copy of the current minimum entry

	// removal scan control
	idx_t   rd_idx_q;       // next old slot to read
	logic   issue_done_q;   // all reads issued
	idx_t   last_q;         // last old slot index
	idx_t   pos_q;          // slot being removed
	logic   vld_s1;         // read data valid this cycle
	idx_t   idx_s1;         // old slot of that data
	logic   have_best_q;
	idx_t   best_pos_q;     // new slot index of best so far
	entry_t best_q;

	// result register
	logic                 out_vld_q;
	logic [OUT_W-1:0]     out_q;
	logic                 out_load;   // a result is written this cycle

	logic   in_fire;
	entry_t in_entry;
	logic   in_take_min;

	logic   cand_ok;
	idx_t   cand_new;
	logic   cand_take;
	logic   have_best_d;
	idx_t   best_pos_d;
	entry_t best_d;
	logic   scan_end;
	count_t rem_count;

	function automatic logic [OUT_W-1:0] pack_out(status_t st, count_t cnt, entry_t m);
		logic [OUT_W-1:0] r;
		logic             empty;
		entry_t           v;
		empty = (cnt == '0);
		v     = empty ? '0 : m;
		r     = {cnt, v.pri, v.elem, empty, st};
		return r;
	endfunction

	assign s_tready = (state_q == S_IDLE) && (!out_vld_q || m_tready);
	assign in_fire  = s_tvalid && s_tready;
	assign in_entry = '{pri: pri_t'(s_tdata[IN_W-1:ELEM_W]), elem: elem_t'(s_tdata[ELEM_W-1:0])};
	assign in_take_min = (count_q == '0) || (in_entry.pri < min_q.pri);

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

	// every item but a remove that starts a scan finishes in the cycle it is taken
	assign out_load = (state_q == S_IDLE) ?
	                  (in_fire && ((mode_t'(s_tuser) == MODE_INSERT) || (count_q == '0))) :
	                  scan_end;

	// candidate from the scan: every old slot but the removed one, renumbered
	assign cand_ok   = vld_s1 && (idx_s1 != pos_q);
	assign cand_new  = (idx_s1 > pos_q) ? idx_s1 - idx_t'(1) : idx_s1;
	assign cand_take = cand_ok && (!have_best_q || (rd_data.pri < best_q.pri));
	assign have_best_d = have_best_q || cand_ok;
	assign best_pos_d  = cand_take ? cand_new : best_pos_q;
	assign best_d      = cand_take ? rd_data : best_q;
	assign scan_end    = vld_s1 && (idx_s1 == last_q);
	assign rem_count   = count_q - count_t'(1);

	// memory port selection: insert writes the tail, the scan moves later slots down one
	always_comb begin
		rd_addr = rd_idx_q;
		wr_en   = 1'b0;
		wr_addr = cand_new;
		wr_data = rd_data;
		if (state_q == S_IDLE) begin
			wr_en   = in_fire && (mode_t'(s_tuser) == MODE_INSERT) &&
			          (count_q < count_t'(CAPACITY));
			wr_addr = count_q[IDX_W-1:0];
			wr_data = in_entry;
		end else begin
			wr_en = vld_s1 && (idx_s1 > pos_q);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			min_pos_q    <= '0;
			out_vld_q    <= 1'b0;
			vld_s1       <= 1'b0;
			issue_done_q <= 1'b0;
			have_best_q  <= 1'b0;
		end else begin
			// a new result only arrives while the old one is gone or leaving
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (mode_t'(s_tuser) == MODE_INSERT) begin
							if (count_q >= count_t'(CAPACITY)) begin
								out_q <= pack_out(ST_FULL, count_q, min_q);
							end else begin
								count_q <= count_q + count_t'(1);
								if (in_take_min) begin
									min_pos_q <= count_q[IDX_W-1:0];
									min_q     <= in_entry;
									out_q     <= pack_out(ST_DONE, count_q + count_t'(1),
									                      in_entry);
								end else begin
									out_q <= pack_out(ST_DONE, count_q + count_t'(1), min_q);
								end
							end
						end else if (count_q == '0) begin
							out_q <= pack_out(ST_EMPTY, count_q, min_q);
						end else begin
							// start the scan over all old slots
							state_q      <= S_SCAN;
							rd_idx_q     <= '0;
							issue_done_q <= 1'b0;
							last_q       <= rem_count[IDX_W-1:0];
							pos_q        <= min_pos_q;
							have_best_q  <= 1'b0;
							best_pos_q   <= '0;
						end
					end
				end
				S_SCAN: begin
					// read data stops once the last slot has been issued
					vld_s1 <= !issue_done_q;
					idx_s1 <= rd_idx_q;
					if (!issue_done_q) begin
						if (rd_idx_q == last_q) begin
							issue_done_q <= 1'b1;
						end else begin
							rd_idx_q <= rd_idx_q + idx_t'(1);
						end
					end
					have_best_q <= have_best_d;
					best_pos_q  <= best_pos_d;
					best_q      <= best_d;
					if (scan_end) begin
						state_q   <= S_IDLE;
						count_q   <= rem_count;
						min_pos_q <= best_pos_d;
						min_q     <= best_d;
						out_q     <= pack_out(ST_DONE, rem_count, best_d);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

[tb/tb_stable_min_priority_queue.sv]
// testbench of the stable minimum priority queue: shadow queue scoreboard and stream drivers
`timescale 1ns / 1ps
module tb_stable_min_priority_queue;
	import spq_pkg::*;

	localparam int CLK_HALF   = 5;
	localparam int HOLD_SPAN  = 200;   // long receiver hold-off, in cycles
	localparam int STALL_MAX  = 5000;  // cycles without any item moving
	localparam int DRAIN_TAIL = 40;    // longer than a removal scan on a full queue

	// one report of the queue, in the order the block packs it
	typedef struct {
		status_t status;
		logic    is_empty;
		elem_t   min_elem;
		pri_t    min_pri;
		count_t  fill;
	} queue_view_t;

	// shadow of the queue contents; works out the report after each item
	class min_queue_shadow;
		elem_t       slot_elem[CAPACITY];
		pri_t        slot_pri[CAPACITY];
		int          held;
		int          min_slot;
		queue_view_t pending_views[$];
		int          errors;

		function void accept_request(mode_t mode, elem_t elem, pri_t pri);
			queue_view_t v;
			v.status = ST_DONE;
			if (mode == MODE_INSERT) begin
				if (held >= CAPACITY) begin
					v.status = ST_FULL;
				end else begin
					slot_elem[held] = elem;
					slot_pri[held]  = pri;
					// only a strictly smaller priority displaces the current minimum
					if (held == 0 || pri < slot_pri[min_slot])
						min_slot = held;
					held++;
				end
			end else if (held == 0) begin
				v.status = ST_EMPTY;
			end else begin
				// close the gap so arrival order is kept, then find the earliest minimum
				for (int i = min_slot; i + 1 < held; i++) begin
					slot_elem[i] = slot_elem[i + 1];
					slot_pri[i]  = slot_pri[i + 1];
				end
				held--;
				min_slot = 0;
				for (int i = 1; i < held; i++)
					if (slot_pri[i] < slot_pri[min_slot])
						min_slot = i;
			end
			v.is_empty = (held == 0);
			v.min_elem = (held > 0) ? slot_elem[min_slot] : '0;
			v.min_pri  = (held > 0) ? slot_pri[min_slot] : '0;
			v.fill     = count_t'(held);
			pending_views.push_back(v);
		endfunction

		function void check_report(logic [OUT_W-1:0] data);
			queue_view_t want;
			status_t     got_status;
			if (pending_views.size() == 0) begin
				$error("report with no item pending: %h", data);
				errors++;
				return;
			end
			want = pending_views.pop_front();
			got_status = status_t'(data[1:0]);
			if (got_status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, data[1:0]);
				errors++;
			end
			if (data[2] !== want.is_empty) begin
				$error("is_empty: expected %0d, got %0d", want.is_empty, data[2]);
				errors++;
			end
			if ($signed(data[34:3]) !== want.min_elem) begin
				$error("min_element: expected %0d, got %0d", want.min_elem, $signed(data[34:3]));
				errors++;
			end
			if ($signed(data[50:35]) !== want.min_pri) begin
				$error("min_priority: expected %0d, got %0d", want.min_pri,
					$signed(data[50:35]));
				errors++;
			end
			if (data[55:51] !== want.fill) begin
				$error("fill_level: expected %0d, got %0d", want.fill, data[55:51]);
				errors++;
			end
		endfunction

		function int pending();
			return pending_views.size();
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic             s_tuser;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;

	min_queue_shadow shadow;
	int              send_idle_pct;
	int              recv_stall_pct;
	bit              hold_req;
	int              quiet_cycles;

	stable_min_priority_queue dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial clk = 1'b0;
	always #CLK_HALF clk = ~clk;

	// scoreboard taps: results first, since a result at this edge is always from an older item
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				shadow.check_report(m_tdata);
			if (s_tvalid && s_tready)
				shadow.accept_request(mode_t'(s_tuser), elem_t'(s_tdata[31:0]),
					pri_t'(s_tdata[47:32]));
		end
	end

	// watchdog on cycles where no item moves on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_MAX) begin
				$display("[stable_min_priority_queue] ERROR");
				$finish;
			end
		end
	end

	// receiver: random stalls, plus one long hold-off on request so the block backs up
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_SPAN) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// offer one item and wait for it to be taken; valid stays up for a following item
	task automatic send_item(mode_t mode, elem_t elem, pri_t pri);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {pri, elem};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// priorities lean toward narrow ranges so ties and stable ordering get exercised
	function automatic pri_t pick_priority();
		case ($urandom_range(3))
			0: return pri_t'($urandom);
			1: return pri_t'($urandom_range(6)) - pri_t'(3);
			2: begin
				case ($urandom_range(3))
					0: return pri_t'(16'sh8000);
					1: return pri_t'(16'sh7fff);
					2: return pri_t'(16'sh8001);
					default: return pri_t'(16'sh0000);
				endcase
			end
			default: return pri_t'($urandom_range(15)) - pri_t'(8);
		endcase
	endfunction

	// random traffic; the insert share swings so the queue keeps running full and empty
	task automatic run_random(int n_items, int idle_pct, int stall_pct);
		int ins_pct;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		ins_pct = 50;
		for (int k = 0; k < n_items; k++) begin
			if (k % 40 == 0) begin
				case ($urandom_range(3))
					0: ins_pct = 20;
					1: ins_pct = 50;
					2: ins_pct = 75;
					default: ins_pct = 92;
				endcase
			end
			if ($urandom_range(99) < ins_pct)
				send_item(MODE_INSERT, elem_t'($urandom), pick_priority());
			else
				send_item(MODE_REMOVE, elem_t'($urandom), pri_t'($urandom));
		end
	endtask

	initial begin
		shadow         = new();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_req       = 1'b0;
		quiet_cycles   = 0;
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tuser        = 1'b0;
		s_tdata        = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: removal on an empty queue, extremes, ties, fill to capacity, overflow
		send_item(MODE_REMOVE, elem_t'(32'h1234_5678), pri_t'(16'sh0001));
		send_item(MODE_INSERT, elem_t'(32'h7fff_ffff), pri_t'(16'sh0000));
		send_item(MODE_INSERT, elem_t'(32'h8000_0000), pri_t'(16'sh7fff));
		send_item(MODE_INSERT, elem_t'(32'h0000_0000), pri_t'(16'sh8000));
		send_item(MODE_INSERT, elem_t'(32'hffff_ffff), pri_t'(16'sh8000));
		send_item(MODE_INSERT, elem_t'(32'h5555_5555), pri_t'(16'shffff));
		send_item(MODE_INSERT, elem_t'(32'haaaa_aaaa), pri_t'(16'sh8000));
		send_item(MODE_INSERT, elem_t'(32'h0000_0001), pri_t'(16'sh5555));
		send_item(MODE_INSERT, elem_t'(32'h8000_0001), pri_t'(16'shaaaa));
		for (int k = 8; k < CAPACITY; k++)
			send_item(MODE_INSERT, elem_t'($urandom), pri_t'(k % 3));
		// queue is full now: this one must be dropped
		send_item(MODE_INSERT, elem_t'(32'hdead_beef), pri_t'(16'sh8000));
		repeat (6)
			send_item(MODE_REMOVE, elem_t'(32'h0), pri_t'(16'sh0));

		run_random(330, 0, 0);
		run_random(330, 65, 0);
		hold_req = 1'b1;
		run_random(330, 0, 65);
		run_random(330, 35, 35);

		s_tvalid <= 1'b0;
		while (shadow.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);

		if (shadow.errors == 0 && shadow.pending() == 0) begin
			$display("[stable_min_priority_queue] OK");
		end else begin
			$display("[stable_min_priority_queue] ERROR");
		end
		$finish;
	end
endmodule
